FILE: hdl/adfu_pkg.sv
// ----------------------------------------------------------------------------
// adfu_pkg: shared types and constants of the autorange display formatter
// Register map, controller states, character phases, command/status bundles.
// ----------------------------------------------------------------------------
package adfu_pkg;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
  localparam logic [1:0] REG_RANGE_HYST  = 2'd1;
  localparam logic [1:0] REG_HOLD_HYST   = 2'd2;
  localparam logic [1:0] REG_UNIT_KIND   = 2'd3;

  // register reset values
  localparam logic [3:0] DIGIT_COUNT_RST = 4'd4;
  localparam logic [7:0] RANGE_HYST_RST  = 8'd26;
  localparam logic [7:0] HOLD_HYST_RST   = 8'd3;
  localparam logic [1:0] UNIT_KIND_RST   = 2'd0;

  // display ranges
  localparam logic [1:0] RANGE_BASE  = 2'd0;
  localparam logic [1:0] RANGE_MILLI = 2'd1;
  localparam logic [1:0] RANGE_MICRO = 2'd2;

  // unit kinds
  localparam logic [1:0] UNIT_VOLT = 2'd0;
  localparam logic [1:0] UNIT_AMP  = 2'd1;
  localparam logic [1:0] UNIT_WATT = 2'd2;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MILLI = 8'h6D;
  localparam logic [7:0] CH_MICRO = 8'h75;
  localparam logic [7:0] CH_VOLT  = 8'h56;
  localparam logic [7:0] CH_AMP   = 8'h41;
  localparam logic [7:0] CH_WATT  = 8'h57;
  localparam logic [7:0] CH_QUERY = 8'h3F;

  typedef struct packed {
    logic [3:0] digit_count;
    logic [7:0] range_hyst;
    logic [7:0] hold_hyst;
    logic [1:0] unit_kind;
  } adfu_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_CHECK,
    ST_INC,
    ST_SETUP,
    ST_EMIT
  } adfu_state_e;

  typedef enum logic [2:0] {
    PH_NINE,
    PH_INT,
    PH_POINT,
    PH_FRAC,
    PH_SPACE,
    PH_PREFIX,
    PH_UNIT
  } adfu_phase_e;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic size;
    logic check;
    logic inc;
    logic setup;
    logic emit;
  } adfu_cmd_t;

  typedef struct packed {
    logic carry;
    logic slot_free;
    logic emit_last;
  } adfu_sts_t;

  function automatic logic [7:0] unit_char(input logic [1:0] kind);
    logic [7:0] c;
    case (kind)
      UNIT_VOLT: c = CH_VOLT;
      UNIT_AMP:  c = CH_AMP;
      UNIT_WATT: c = CH_WATT;
      default:   c = CH_QUERY;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/adfu_regs.sv
// ----------------------------------------------------------------------------
// adfu_regs: configuration register file
// APB-style write/read port for digit count, hysteresis and unit kind.
// ----------------------------------------------------------------------------
module adfu_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output adfu_pkg::adfu_cfg_t  cfg_o
);

  adfu_pkg::adfu_cfg_t cfg_q, cfg_d;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        adfu_pkg::REG_DIGIT_COUNT: cfg_d.digit_count = pwdata[3:0];
        adfu_pkg::REG_RANGE_HYST:  cfg_d.range_hyst  = pwdata[7:0];
        adfu_pkg::REG_HOLD_HYST:   cfg_d.hold_hyst   = pwdata[7:0];
        adfu_pkg::REG_UNIT_KIND:   cfg_d.unit_kind   = pwdata[1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.digit_count <= adfu_pkg::DIGIT_COUNT_RST;
      cfg_q.range_hyst  <= adfu_pkg::RANGE_HYST_RST;
      cfg_q.hold_hyst   <= adfu_pkg::HOLD_HYST_RST;
      cfg_q.unit_kind   <= adfu_pkg::UNIT_KIND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (paddr[3:2])
      adfu_pkg::REG_DIGIT_COUNT: prdata = {28'd0, cfg_q.digit_count};
      adfu_pkg::REG_RANGE_HYST:  prdata = {24'd0, cfg_q.range_hyst};
      adfu_pkg::REG_HOLD_HYST:   prdata = {24'd0, cfg_q.hold_hyst};
      adfu_pkg::REG_UNIT_KIND:   prdata = {30'd0, cfg_q.unit_kind};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/adfu_ctrl.sv
// ----------------------------------------------------------------------------
// adfu_ctrl: sequencing state machine
// Steps one reading through conversion, sizing, rounding and character output.
// ----------------------------------------------------------------------------
module adfu_ctrl #(
  parameter int READING_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  adfu_pkg::adfu_sts_t  sts_i,
  output adfu_pkg::adfu_cmd_t  cmd_o
);

  localparam int CNW = $clog2(READING_BITS);

  adfu_pkg::adfu_state_e state_q, state_d;
  logic [CNW-1:0]        cnt_q, cnt_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      adfu_pkg::ST_IDLE:  if (in_valid_i) state_d = adfu_pkg::ST_CONV;
      adfu_pkg::ST_CONV:  if (cnt_q == CNW'(READING_BITS - 1)) state_d = adfu_pkg::ST_SIZE;
      adfu_pkg::ST_SIZE:  state_d = adfu_pkg::ST_CHECK;
      adfu_pkg::ST_CHECK: state_d = adfu_pkg::ST_INC;
      adfu_pkg::ST_INC:   if (!sts_i.carry) state_d = adfu_pkg::ST_SETUP;
      adfu_pkg::ST_SETUP: state_d = adfu_pkg::ST_EMIT;
      adfu_pkg::ST_EMIT: begin
        if (sts_i.slot_free && sts_i.emit_last) state_d = adfu_pkg::ST_IDLE;
      end
      default:            state_d = adfu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      adfu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      adfu_pkg::ST_CONV:  cmd_o.conv_step = 1'b1;
      adfu_pkg::ST_SIZE:  cmd_o.size      = 1'b1;
      adfu_pkg::ST_CHECK: cmd_o.check     = 1'b1;
      adfu_pkg::ST_INC:   cmd_o.inc       = 1'b1;
      adfu_pkg::ST_SETUP: cmd_o.setup     = 1'b1;
      adfu_pkg::ST_EMIT:  cmd_o.emit      = sts_i.slot_free;
      default:            cmd_o           = '0;
    endcase
  end

  // bit counter of the conversion
  always_comb begin
    cnt_d = cnt_q;
    if (state_q == adfu_pkg::ST_CONV) cnt_d = cnt_q + 1'b1;
    else                              cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adfu_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: hdl/adfu_dp.sv
// ----------------------------------------------------------------------------
// adfu_dp: formatter datapath
// Range and hold update, bit-serial BCD conversion, digit rounding and the
// character generator with its output register.
// ----------------------------------------------------------------------------
module adfu_dp #(
  parameter int READING_BITS = 32,
  parameter int MAX_DIGITS   = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  adfu_pkg::adfu_cmd_t      cmd_i,
  output adfu_pkg::adfu_sts_t      sts_o,
  input  adfu_pkg::adfu_cfg_t      cfg_i,
  input  logic [READING_BITS-1:0]  reading_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [7:0]               out_char_o,
  output logic [1:0]               out_range_o,
  output logic                     out_last_o
);

  localparam int RB  = READING_BITS;
  // decimal digits of the largest magnitude plus one for a rounding carry
  localparam int ND  = ((RB - 1) * 30103) / 100000 + 2;
  localparam int IW  = $clog2(ND);
  localparam int LW  = $clog2(ND + MAX_DIGITS + 1);
  localparam int PSW = $clog2(ND + MAX_DIGITS + 2) + 1;
  localparam int CW  = (RB + 10 > 32) ? RB + 10 : 32;

  localparam logic signed [CW-1:0] ONE_K = CW'(1000);
  localparam logic signed [CW-1:0] ONE_M = CW'(1000000);

  // state
  logic [1:0]                range_q;
  logic signed [RB-1:0]      held_q;
  logic [RB-1:0]             sh_q;
  logic [3:0]                dig_q [ND];
  logic [LW-1:0]             rem_q;
  logic [LW-1:0]             cnt_q;
  logic                      rnd_en_q;
  logic                      carry_q;
  logic signed [PSW-1:0]     pos_q;
  adfu_pkg::adfu_phase_e     phase_q;
  logic                      out_valid_q;
  logic [7:0]                out_char_q;
  logic [1:0]                out_range_q;
  logic                      out_last_q;

  // ---------------- range choice and hold update ----------------
  logic signed [CW-1:0] r_ext, h_ext, r256, thr_milli, thr_base, p_up, p_dn;
  logic                 r_lt, r_gt, held_upd;
  logic [1:0]           range_nx;
  logic [RB-1:0]        mag;

  assign r_ext     = {{(CW-RB){reading_i[RB-1]}}, reading_i};
  assign h_ext     = {{(CW-RB){held_q[RB-1]}}, held_q};
  assign r256      = r_ext <<< 8;
  assign thr_milli = $signed(CW'(256000) + CW'(1000) * CW'(cfg_i.range_hyst));
  assign thr_base  = $signed(CW'(256000000) + CW'(1000000) * CW'(cfg_i.range_hyst));
  assign p_up      = h_ext * $signed({1'b0, 9'd256 + 9'(cfg_i.hold_hyst)});
  assign p_dn      = h_ext * $signed({1'b0, 9'd256 - 9'(cfg_i.hold_hyst)});
  assign r_lt      = r_ext < h_ext;
  assign r_gt      = r_ext > h_ext;
  assign held_upd  = (r256 > p_up) || (r256 > p_dn);
  assign mag       = reading_i[RB-1] ? (~reading_i + 1'b1) : reading_i;

  always_comb begin
    range_nx = range_q;
    case (range_q)
      adfu_pkg::RANGE_BASE: begin
        if (r_lt && r_ext <= ONE_M) range_nx = adfu_pkg::RANGE_MILLI;
      end
      adfu_pkg::RANGE_MILLI: begin
        if (r_lt && r_ext <= ONE_K) range_nx = adfu_pkg::RANGE_MICRO;
        else if (r_gt && r_ext >= ONE_M && r256 > thr_base) range_nx = adfu_pkg::RANGE_BASE;
      end
      adfu_pkg::RANGE_MICRO: begin
        if (r_gt && r_ext >= ONE_K && r256 > thr_milli) range_nx = adfu_pkg::RANGE_MILLI;
      end
      default: range_nx = range_q;
    endcase
  end

  // ---------------- double-dabble step ----------------
  logic [3:0] adj   [ND];
  logic [3:0] dd_nx [ND];
  logic       bcd_ok;

  always_comb begin
    bcd_ok = 1'b1;
    for (int i = 0; i < ND; i++) begin
      adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
      if (dig_q[i] > 4'd9) bcd_ok = 1'b0;
    end
    dd_nx[0] = {adj[0][2:0], sh_q[RB-1]};
    for (int i = 1; i < ND; i++) begin
      dd_nx[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // ---------------- sizing ----------------
  logic signed [PSW-1:0] hi_v, s_v, span_v;
  logic [LW-1:0]         len_v, d_v, rem_v, s_l;
  logic                  nines_v;

  always_comb begin
    hi_v = '1;  // no nonzero digit
    for (int i = 0; i < ND; i++) begin
      if (dig_q[i] != 4'd0) hi_v = PSW'(i);
    end
    case (range_q)
      adfu_pkg::RANGE_BASE:  s_v = PSW'(6);
      adfu_pkg::RANGE_MILLI: s_v = PSW'(3);
      default:               s_v = PSW'(0);
    endcase
    s_l    = s_v[LW-1:0];
    span_v = hi_v - s_v + PSW'(1);
    len_v  = (hi_v >= s_v) ? span_v[LW-1:0] : LW'(1);
    // clamp the digit count to 1..MAX_DIGITS
    if (cfg_i.digit_count == 4'd0)                 d_v = LW'(1);
    else if (LW'(cfg_i.digit_count) > LW'(MAX_DIGITS)) d_v = LW'(MAX_DIGITS);
    else                                           d_v = LW'(cfg_i.digit_count);
    nines_v = len_v > d_v;
    rem_v   = nines_v ? '0 : d_v - len_v;
  end

  // ---------------- digit read port ----------------
  logic       pos_ok;
  logic [3:0] rd_dig;

  assign pos_ok = (pos_q >= 0) && (pos_q < PSW'(ND));
  assign rd_dig = pos_ok ? dig_q[pos_q[IW-1:0]] : 4'd0;

  // ---------------- character generator ----------------
  logic [7:0] ch_v;
  logic       last_v;

  always_comb begin
    case (phase_q)
      adfu_pkg::PH_NINE:   ch_v = adfu_pkg::CH_NINE;
      adfu_pkg::PH_INT:    ch_v = adfu_pkg::CH_ZERO + 8'(rd_dig);
      adfu_pkg::PH_POINT:  ch_v = adfu_pkg::CH_POINT;
      adfu_pkg::PH_FRAC:   ch_v = adfu_pkg::CH_ZERO + 8'(rd_dig);
      adfu_pkg::PH_SPACE:  ch_v = adfu_pkg::CH_SPACE;
      adfu_pkg::PH_PREFIX: begin
        ch_v = (range_q == adfu_pkg::RANGE_MILLI) ? adfu_pkg::CH_MILLI : adfu_pkg::CH_MICRO;
      end
      adfu_pkg::PH_UNIT:   ch_v = adfu_pkg::unit_char(cfg_i.unit_kind);
      default:             ch_v = adfu_pkg::CH_QUERY;
    endcase
    last_v = phase_q == adfu_pkg::PH_UNIT;
  end

  // ---------------- sequenced registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q  <= adfu_pkg::RANGE_MICRO;
      held_q   <= '0;
      carry_q  <= 1'b0;
      rnd_en_q <= 1'b0;
      phase_q  <= adfu_pkg::PH_UNIT;
    end else begin
      if (cmd_i.load) begin
        range_q <= range_nx;
        if (held_upd) held_q <= reading_i;
        carry_q <= 1'b0;
      end
      if (cmd_i.size) begin
        rnd_en_q <= !nines_v && (rem_v < s_l);
      end
      if (cmd_i.check) begin
        carry_q <= rnd_en_q && (rd_dig >= 4'd5);
      end
      if (cmd_i.inc && carry_q) begin
        carry_q <= pos_ok && (rd_dig == 4'd9);
      end
      if (cmd_i.setup) begin
        phase_q <= nines_v ? adfu_pkg::PH_NINE : adfu_pkg::PH_INT;
      end
      if (cmd_i.emit) begin
        case (phase_q)
          adfu_pkg::PH_NINE: begin
            if (cnt_q == LW'(1)) phase_q <= adfu_pkg::PH_SPACE;
          end
          adfu_pkg::PH_INT: begin
            if (cnt_q == LW'(1)) begin
              phase_q <= (rem_q != '0) ? adfu_pkg::PH_POINT : adfu_pkg::PH_SPACE;
            end
          end
          adfu_pkg::PH_POINT: phase_q <= adfu_pkg::PH_FRAC;
          adfu_pkg::PH_FRAC: begin
            if (cnt_q == LW'(1)) phase_q <= adfu_pkg::PH_SPACE;
          end
          adfu_pkg::PH_SPACE: begin
            phase_q <= (range_q != adfu_pkg::RANGE_BASE) ? adfu_pkg::PH_PREFIX
                                                         : adfu_pkg::PH_UNIT;
          end
          adfu_pkg::PH_PREFIX: phase_q <= adfu_pkg::PH_UNIT;
          default:             phase_q <= adfu_pkg::PH_UNIT;
        endcase
      end
    end
  end

  // payload: conversion shifter, digits, pointer, counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sh_q <= mag;
      for (int i = 0; i < ND; i++) dig_q[i] <= 4'd0;
    end
    if (cmd_i.conv_step) begin
      sh_q <= sh_q << 1;
      for (int i = 0; i < ND; i++) dig_q[i] <= dd_nx[i];
    end
    if (cmd_i.size) begin
      pos_q <= s_v - $signed({1'b0, rem_v}) - PSW'(1);
    end
    if (cmd_i.check) begin
      pos_q <= pos_q + PSW'(1);
    end
    if (cmd_i.inc && carry_q) begin
      if (pos_ok) dig_q[pos_q[IW-1:0]] <= (rd_dig == 4'd9) ? 4'd0 : rd_dig + 4'd1;
      pos_q <= pos_q + PSW'(1);
    end
    if (cmd_i.setup) begin
      rem_q <= rem_v;
      cnt_q <= nines_v ? d_v : len_v;
      pos_q <= s_v + $signed({1'b0, len_v}) - PSW'(1);
    end
    if (cmd_i.emit) begin
      case (phase_q)
        adfu_pkg::PH_NINE:  cnt_q <= cnt_q - 1'b1;
        adfu_pkg::PH_INT: begin
          cnt_q <= cnt_q - 1'b1;
          pos_q <= pos_q - PSW'(1);
        end
        adfu_pkg::PH_POINT: cnt_q <= rem_q;
        adfu_pkg::PH_FRAC: begin
          cnt_q <= cnt_q - 1'b1;
          pos_q <= pos_q - PSW'(1);
        end
        default:            cnt_q <= cnt_q;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_char_q  <= ch_v;
      out_range_q <= range_q;
      out_last_q  <= last_v;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign out_range_o     = out_range_q;
  assign out_last_o      = out_last_q;
  assign sts_o.carry     = carry_q;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = last_v;

`ifndef NO_ASSERTIONS
  // a character is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("adfu_dp: output register overwritten");

  // the decimal digits stay valid BCD once loaded
  a_bcd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.size || cmd_i.check || cmd_i.inc || cmd_i.setup || cmd_i.emit) |-> bcd_ok)
    else $error("adfu_dp: digit out of BCD range");

  // rounding starts with no pending carry
  a_carry_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> !carry_q)
    else $error("adfu_dp: stale rounding carry");

  // the unit letter closes every string
  a_last_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (out_last_q == (($past(phase_q)) == adfu_pkg::PH_UNIT)))
    else $error("adfu_dp: end-of-string mark misplaced");
`endif

endmodule

FILE: hdl/autorange_display_formatter_unit.sv
// ----------------------------------------------------------------------------
// autorange_display_formatter_unit: autoranging fixed-digit display formatter
// Turns signed micro-unit readings into ASCII display strings.
// ----------------------------------------------------------------------------
// Each reading accepted on the input stream selects a base/milli/micro range
// with upward hysteresis and is emitted as one character beat per output beat
// (digits, optional point, space, optional prefix, unit letter; tlast on the
// unit). A reading passes through the bit-serial binary-to-BCD converter,
// sizing and setup and a rounding step while a carry ripples through the
// digits, then character output (at most MAX_DIGITS + 4 characters), which
// stalls while the output is not ready. The next reading is taken once the
// last character sits in the output register. Negative readings show their
// magnitude.
module autorange_display_formatter_unit #(
  parameter int READING_BITS = 32,
  parameter int MAX_DIGITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((READING_BITS+7)/8)*8-1:0]   s_axis_tdata,  // [RB-1:0] reading_micro
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] char_code
  output logic [1:0]                          m_axis_tuser,  // [1:0] range_now
  output logic                                m_axis_tlast,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  adfu_pkg::adfu_cfg_t cfg;
  adfu_pkg::adfu_cmd_t cmd;
  adfu_pkg::adfu_sts_t sts;

  adfu_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  adfu_ctrl #(
    .READING_BITS (READING_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adfu_dp #(
    .READING_BITS (READING_BITS),
    .MAX_DIGITS   (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_i       (cfg),
    .reading_i   (s_axis_tdata[READING_BITS-1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_range_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

FILE: tb/sv/tb_autorange_display_formatter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_autorange_display_formatter_unit: self-checking bench of the formatter
// Drives micro-unit readings over the input stream, predicts every display
// character with range and hold hysteresis, and checks each output beat.
// ----------------------------------------------------------------------------

typedef struct {
  logic [7:0] code;
  logic [1:0] rng;
  logic       last;
} char_beat_t;

class char_scoreboard;
  char_beat_t pending[$];
  int         mismatches;
  logic [3:0] digits;
  logic [7:0] rhyst;
  logic [7:0] hhyst;
  logic [1:0] unit;
  logic [1:0] range_q;
  longint     held_q;

  function new();
    digits = adfu_pkg::DIGIT_COUNT_RST; rhyst = adfu_pkg::RANGE_HYST_RST;
    hhyst = adfu_pkg::HOLD_HYST_RST; unit = adfu_pkg::UNIT_KIND_RST;
    range_q = adfu_pkg::RANGE_MICRO; held_q = 0;
    mismatches = 0;
  endfunction

  function longint pow10(int n);
    longint p;
    p = 1;
    for (int k = 0; k < n; k++) p = p * 10;
    return p;
  endfunction

  function int ndigits(longint v);
    int n;
    n = 1;
    while (n < 19 && v >= pow10(n)) n++;
    return n;
  endfunction

  function void push(logic [7:0] c, logic [1:0] rng);
    char_beat_t b;
    b.code = c; b.rng = rng; b.last = 1'b0;
    pending.push_back(b);
  endfunction

  // note an accepted reading: choose range, queue its characters, update hold
  function void note_reading(logic [31:0] raw);
    longint r, m, q, ip, fp, fr, dv;
    int     d, s, len, rem;
    logic [1:0] ns;
    logic [7:0] uc;
    r = longint'(signed'(raw));
    ns = range_q;
    if (range_q == adfu_pkg::RANGE_BASE && r < held_q && r <= 1000000)
      ns = adfu_pkg::RANGE_MILLI;
    else if (range_q == adfu_pkg::RANGE_MILLI && r < held_q && r <= 1000)
      ns = adfu_pkg::RANGE_MICRO;
    else if (range_q == adfu_pkg::RANGE_MICRO && r > held_q && r >= 1000 &&
             r * 256 > 1000 * (256 + longint'(rhyst))) ns = adfu_pkg::RANGE_MILLI;
    else if (range_q == adfu_pkg::RANGE_MILLI && r > held_q && r >= 1000000 &&
             r * 256 > 1000000 * (256 + longint'(rhyst))) ns = adfu_pkg::RANGE_BASE;
    range_q = ns;
    d = digits;
    if (d < 1) d = 1;
    if (d > 8) d = 8;
    m = r < 0 ? -r : r;
    s = ns == adfu_pkg::RANGE_BASE ? 6 : (ns == adfu_pkg::RANGE_MILLI ? 3 : 0);
    q = pow10(s);
    ip = m / q; fp = m % q;
    len = ndigits(ip); rem = 0; fr = 0;
    if (len <= d) begin
      rem = d - len;
      if (rem >= s) fr = fp * pow10(rem - s);
      else begin
        dv = pow10(s - rem);
        fr = (fp + dv / 2) / dv;
      end
      // rounding carry into the integer part
      if (fr >= pow10(rem)) begin
        ip++; fr = 0; len = ndigits(ip);
        rem = len <= d ? d - len : 0;
      end
    end
    if (len > d) begin
      for (int k = 0; k < d; k++) push(adfu_pkg::CH_NINE, ns);
    end else begin
      for (int k = len; k > 0; k--)
        push(adfu_pkg::CH_ZERO + 8'((ip / pow10(k - 1)) % 10), ns);
      if (rem > 0) begin
        push(adfu_pkg::CH_POINT, ns);
        for (int k = rem; k > 0; k--)
          push(adfu_pkg::CH_ZERO + 8'((fr / pow10(k - 1)) % 10), ns);
      end
    end
    push(adfu_pkg::CH_SPACE, ns);
    if (ns == adfu_pkg::RANGE_MILLI) push(adfu_pkg::CH_MILLI, ns);
    else if (ns == adfu_pkg::RANGE_MICRO) push(adfu_pkg::CH_MICRO, ns);
    case (unit)
      adfu_pkg::UNIT_VOLT: uc = adfu_pkg::CH_VOLT;
      adfu_pkg::UNIT_AMP:  uc = adfu_pkg::CH_AMP;
      adfu_pkg::UNIT_WATT: uc = adfu_pkg::CH_WATT;
      default:             uc = adfu_pkg::CH_QUERY;
    endcase
    push(uc, ns);
    pending[$].last = 1'b1;
    if (r * 256 > held_q * (256 + longint'(hhyst)) ||
        r * 256 > held_q * (256 - longint'(hhyst))) held_q = r;
  endfunction

  function void check_beat(logic [7:0] c, logic [1:0] rng, logic last);
    char_beat_t e;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat: char %h range %0d last %b", c, rng, last);
      return;
    end
    e = pending.pop_front();
    if (c !== e.code || rng !== e.rng || last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("beat mismatch: exp %h/%0d/%b got %h/%0d/%b",
                 e.code, e.rng, e.last, c, rng, last);
    end
  endfunction
endclass

module tb_autorange_display_formatter_unit;
  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] reading_micro
  logic        m_axis_tvalid, m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] char_code
  logic [1:0]  m_axis_tuser;   // [1:0] range_now
  logic        m_axis_tlast;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  char_scoreboard sb;
  int  cycles;
  int  hold_off;     // long receiver hold-off in cycles
  bit  stall_on;

  autorange_display_formatter_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // receiver: stall pattern plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_on) m_axis_tready <= ($urandom_range(0, 3) != 0);
    else m_axis_tready <= 1'b1;
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      adfu_pkg::REG_DIGIT_COUNT: sb.digits = val[3:0];
      adfu_pkg::REG_RANGE_HYST:  sb.rhyst = val[7:0];
      adfu_pkg::REG_HOLD_HYST:   sb.hhyst = val[7:0];
      default:                   sb.unit = val[1:0];
    endcase
    @(posedge clk_i);
  endtask

  // offer one reading and wait until it is taken; valid stays up for the next
  task automatic send_reading(logic [31:0] v);
    s_axis_tvalid <= 1'b1; s_axis_tdata <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_reading(v);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // random reading: any value, near the milli or base threshold, up to 99999999, negative, or up to 1000000
  function automatic logic [31:0] pick_reading();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 2000);
      2: return $urandom_range(900000, 1300000);
      3: return $urandom_range(0, 99999999);
      4: return -$urandom_range(0, 5000000);
      default: return $urandom_range(0, 1000000);
    endcase
  endfunction

  task automatic random_burst(int count);
    int left;
    int gap;
    left = count;
    while (left > 0) begin
      for (int b = $urandom_range(1, 8); b > 0 && left > 0; b--) begin
        send_reading(pick_reading());
        left--;
      end
      gap = $urandom_range(0, 60);
      if (gap > 0) s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    m_axis_tready = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; hold_off = 0; stall_on = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, threshold crossings, rounding carry, overflow
    send_reading(32'd0);
    send_reading(32'h7FFFFFFF);
    send_reading(32'h80000000);
    send_reading(32'd999);
    send_reading(32'd1000);
    send_reading(32'd1200);
    send_reading(32'd999999);
    send_reading(32'd1500000);
    send_reading(32'd1100000);
    send_reading(32'd9999999);
    send_reading(32'd500);
    send_reading(-32'd1234567);
    send_reading(32'hFFFFFFFF);
    drain();
    reg_write(adfu_pkg::REG_DIGIT_COUNT, 32'd0);
    reg_write(adfu_pkg::REG_UNIT_KIND, 32'd3);
    reg_write(adfu_pkg::REG_RANGE_HYST, 32'd0);
    reg_write(adfu_pkg::REG_HOLD_HYST, 32'd255);
    send_reading(32'd9500);
    send_reading(32'd2000000);
    send_reading(32'd12);
    drain();
    reg_write(adfu_pkg::REG_DIGIT_COUNT, 32'd15);
    reg_write(adfu_pkg::REG_UNIT_KIND, 32'd1);
    reg_write(adfu_pkg::REG_RANGE_HYST, 32'd255);
    reg_write(adfu_pkg::REG_HOLD_HYST, 32'd0);
    send_reading(32'd99999999);
    send_reading(32'd123456789);
    send_reading(32'd5000);
    drain();

    // random phases with several register settings
    stall_on = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(adfu_pkg::REG_DIGIT_COUNT, $urandom_range(0, 15));
      reg_write(adfu_pkg::REG_RANGE_HYST, $urandom_range(0, 255));
      reg_write(adfu_pkg::REG_HOLD_HYST, $urandom_range(0, 255));
      reg_write(adfu_pkg::REG_UNIT_KIND, ph % 4 == 3 ? 2 : $urandom_range(0, 3));
      if (ph == 1) hold_off = 600;   // block backs up while readings keep coming
      random_burst(38);
      if (ph == 3) stall_on = 1'b0;  // final drain without receiver stalls
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/adfu_pkg.sv
hdl/adfu_regs.sv
hdl/adfu_ctrl.sv
hdl/adfu_dp.sv
hdl/autorange_display_formatter_unit.sv
tb/sv/tb_autorange_display_formatter_unit.sv
